FILE: sv/cwlt_pkg.sv
`default_nettype none

package cwlt_pkg;

    // Storage geometry.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths.
    localparam int OP_W     = 3;
    localparam int WORD_W   = 16;
    localparam int AMT_W    = 8;
    localparam int IDX_W    = 7;
    localparam int LEN_W    = 2;
    localparam int CTX_LEN  = 3;

    // Signed width that holds a cursor plus any displacement.
    localparam int MV_W     = ((CNT_W > AMT_W - 1) ? CNT_W : AMT_W - 1) + 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_MOVE     = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_NEXT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_PREV = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

    // Controller to datapath.
    typedef struct packed {
        logic start;  // word accepted: decide and latch the operation
        logic shift;  // step the shift engine
        logic put;    // write the inserted word
        logic ctx;    // step the context reader
        logic load;   // move the finished result into the output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic put_pending;  // an accepted insert still has to write its word
        logic send;         // result carries context words
        logic rem_zero;     // no shift step left
        logic ctx_done;     // all context reads issued
    } status_t;

endpackage

`default_nettype wire

FILE: sv/cwlt_ram.sv
`default_nettype none

module cwlt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/cwlt_ctrl.sv
`default_nettype none

module cwlt_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire cwlt_pkg::status_t status,
    output cwlt_pkg::cmd_t         cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_CTX    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                // The last pending write lands in the cycle the count runs out.
                if (status.rem_zero) begin
                    priority if (status.put_pending) begin
                        state_next = S_PUT;
                    end else if (status.send) begin
                        state_next = S_CTX;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_PUT: begin
                cmd.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_CTX: begin
                cmd.ctx = 1'b1;
                if (status.ctx_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cwlt_datapath.sv
`default_nettype none

module cwlt_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire cwlt_pkg::cmd_t                      cmd,
    output cwlt_pkg::status_t                        status,
    input  wire logic [cwlt_pkg::OP_W-1:0]           in_op,
    input  wire logic [cwlt_pkg::WORD_W-1:0]         in_word,
    input  wire logic signed [cwlt_pkg::AMT_W-1:0]   in_amount,
    input  wire logic                                in_allow_same,
    output logic                                     out_ok,
    output logic [cwlt_pkg::IDX_W-1:0]               out_cursor_index,
    output logic [cwlt_pkg::IDX_W-1:0]               out_word_count,
    output logic                                     out_trigram_sent,
    output logic [cwlt_pkg::LEN_W-1:0]               out_trigram_len,
    output logic [cwlt_pkg::WORD_W-1:0]              out_context_word1,
    output logic [cwlt_pkg::WORD_W-1:0]              out_context_word2,
    output logic [cwlt_pkg::WORD_W-1:0]              out_context_word3
);

    localparam int CNT_W  = cwlt_pkg::CNT_W;
    localparam int ADDR_W = cwlt_pkg::ADDR_W;
    localparam int MV_W   = cwlt_pkg::MV_W;
    localparam int WORD_W = cwlt_pkg::WORD_W;
    localparam int LEN_W  = cwlt_pkg::LEN_W;
    localparam int IDX_W  = cwlt_pkg::IDX_W;

    // List state.
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // Per-operation registers.
    logic              ok_reg, ok_next;
    logic              send_reg, send_next;
    logic              put_pend_reg, put_pend_next;
    logic              down_reg, down_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ADDR_W-1:0] put_addr_reg, put_addr_next;
    logic [WORD_W-1:0] word_reg;

    // Shift write pipeline.
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;

    // Context reader.
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  ctx_k_reg, ctx_k_next;
    logic              cap_valid_reg, cap_valid_next;
    logic [LEN_W-1:0]  cap_slot_reg, cap_slot_next;
    logic [WORD_W-1:0] ctx_word_reg [cwlt_pkg::CTX_LEN];

    // Memory ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr, ctx_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    // Decision logic.
    logic signed [MV_W-1:0] new_pos;
    logic                   move_ok;
    logic                   shift_issue, ctx_issue;
    logic [IDX_W-1:0]       index_wide;

    assign new_pos = $signed({{(MV_W-CNT_W){1'b0}}, cursor_reg}) + MV_W'(in_amount);
    assign move_ok = (count_reg != '0) && !new_pos[MV_W-1]
                  && (new_pos <= $signed({{(MV_W-CNT_W){1'b0}}, count_reg}))
                  && ((in_amount != '0) || in_allow_same);

    always_comb begin
        cursor_next   = cursor_reg;
        count_next    = count_reg;
        ok_next       = ok_reg;
        send_next     = send_reg;
        put_pend_next = put_pend_reg;
        down_next     = down_reg;
        ptr_next      = ptr_reg;
        rem_next      = rem_reg;
        put_addr_next = put_addr_reg;
        len_next      = len_reg;
        if (cmd.start) begin
            ok_next       = 1'b0;
            send_next     = 1'b0;
            put_pend_next = 1'b0;
            down_next     = 1'b0;
            rem_next      = '0;
            ptr_next      = ptr_reg;
            put_addr_next = cursor_reg[ADDR_W-1:0];
            unique case (in_op)
                cwlt_pkg::OP_INSERT: begin
                    if (count_reg < CNT_W'(cwlt_pkg::CAPACITY)) begin
                        ok_next       = 1'b1;
                        put_pend_next = 1'b1;
                        down_next     = 1'b1;
                        ptr_next      = ADDR_W'(count_reg - 1'b1);
                        rem_next      = count_reg - cursor_reg;
                        count_next    = count_reg + 1'b1;
                        cursor_next   = cursor_reg + 1'b1;
                    end
                end
                cwlt_pkg::OP_MOVE: begin
                    if (move_ok) begin
                        ok_next     = 1'b1;
                        send_next   = 1'b1;
                        cursor_next = new_pos[CNT_W-1:0];
                    end
                end
                cwlt_pkg::OP_DEL_NEXT: begin
                    if ((count_reg != '0) && (cursor_reg < count_reg)) begin
                        ok_next    = 1'b1;
                        ptr_next   = ADDR_W'(cursor_reg + 1'b1);
                        rem_next   = count_reg - cursor_reg - 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                cwlt_pkg::OP_DEL_PREV: begin
                    if ((count_reg != '0) && (cursor_reg != '0)) begin
                        ok_next     = 1'b1;
                        send_next   = 1'b1;
                        ptr_next    = cursor_reg[ADDR_W-1:0];
                        rem_next    = count_reg - cursor_reg;
                        count_next  = count_reg - 1'b1;
                        cursor_next = cursor_reg - 1'b1;
                    end
                end
                cwlt_pkg::OP_CLEAR: begin
                    ok_next     = 1'b1;
                    count_next  = '0;
                    cursor_next = '0;
                end
                default: begin
                end
            endcase
        end else if (shift_issue) begin
            ptr_next = down_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
            rem_next = rem_reg - 1'b1;
        end
        if (cmd.put) begin
            put_pend_next = 1'b0;
        end
        // The context length follows the cursor once the operation has settled.
        if (!send_reg) begin
            len_next = '0;
        end else if (cursor_reg >= CNT_W'(cwlt_pkg::CTX_LEN)) begin
            len_next = LEN_W'(cwlt_pkg::CTX_LEN);
        end else begin
            len_next = cursor_reg[LEN_W-1:0];
        end
    end

    // Shift engine: read one entry per cycle, write it one slot over in the next cycle.
    assign shift_issue     = cmd.shift && (rem_reg != '0);
    assign pend_valid_next = shift_issue;
    assign pend_addr_next  = down_reg ? ptr_reg + 1'b1 : ptr_reg - 1'b1;

    // Context reader: nearest word first.
    assign ctx_issue      = cmd.ctx && (ctx_k_reg < len_reg);
    assign ctx_addr       = ADDR_W'(cursor_reg - 1'b1 - CNT_W'(ctx_k_reg));
    assign ctx_k_next     = cmd.start ? '0 : (ctx_issue ? ctx_k_reg + 1'b1 : ctx_k_reg);
    assign cap_valid_next = ctx_issue;
    assign cap_slot_next  = ctx_k_reg;

    assign ram_raddr = cmd.ctx ? ctx_addr : ptr_reg;
    assign ram_we    = pend_valid_reg || cmd.put;
    assign ram_waddr = cmd.put ? put_addr_reg : pend_addr_reg;
    assign ram_wdata = cmd.put ? word_reg : ram_rdata;

    cwlt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (cwlt_pkg::CAPACITY)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.put_pending = put_pend_reg;
    assign status.send        = send_reg;
    assign status.rem_zero    = (rem_reg == '0);
    assign status.ctx_done    = (ctx_k_reg == len_reg);

    assign index_wide = IDX_W'(cursor_reg) - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg     <= '0;
            count_reg      <= '0;
            ok_reg         <= 1'b0;
            send_reg       <= 1'b0;
            put_pend_reg   <= 1'b0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            len_reg        <= '0;
            ctx_k_reg      <= '0;
            cap_valid_reg  <= 1'b0;
        end else begin
            cursor_reg     <= cursor_next;
            count_reg      <= count_next;
            ok_reg         <= ok_next;
            send_reg       <= send_next;
            put_pend_reg   <= put_pend_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            len_reg        <= len_next;
            ctx_k_reg      <= ctx_k_next;
            cap_valid_reg  <= cap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        down_reg      <= down_next;
        ptr_reg       <= ptr_next;
        put_addr_reg  <= put_addr_next;
        pend_addr_reg <= pend_addr_next;
        cap_slot_reg  <= cap_slot_next;
        if (cmd.start) begin
            word_reg <= in_word;
        end
        for (int i = 0; i < cwlt_pkg::CTX_LEN; i++) begin
            if (cmd.start) begin
                ctx_word_reg[i] <= '0;
            end else if (cap_valid_reg && (cap_slot_reg == LEN_W'(i))) begin
                ctx_word_reg[i] <= ram_rdata;
            end
        end
        if (cmd.load) begin
            out_ok            <= ok_reg;
            out_cursor_index  <= index_wide;
            out_word_count    <= IDX_W'(count_reg);
            out_trigram_sent  <= send_reg;
            out_trigram_len   <= len_reg;
            out_context_word1 <= ctx_word_reg[0];
            out_context_word2 <= ctx_word_reg[1];
            out_context_word3 <= ctx_word_reg[2];
        end
    end

endmodule

`default_nettype wire

FILE: sv/cursor_word_list_with_trigram.sv
`default_nettype none

// Ordered list of up to 64 word identifiers with an edit cursor between
// entries. Each input word is one operation, selected by s_tuser: insert
// before the cursor, move the cursor by a signed amount, delete the entry
// after or before the cursor, or clear. Every operation returns exactly one
// result word with the ok flag, the index of the entry just before the
// cursor (-1 at the start) and the number of entries held. A successful move
// or delete-previous also returns up to three entries before the cursor,
// nearest first, and raises m_tuser. One operation is handled at a time: the
// input is held while the block decides the operation, shifts the entries
// that an insert or a delete moves through the word memory, writes the
// inserted word, reads the context words and hands the result over. The
// shift loop through the memory is the longest of these steps. A finished
// result waits in an output register, so the next operation is taken while
// it is still pending.

module cursor_word_list_with_trigram (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Operation channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, from bit 0: word[15:0], amount[23:16] (signed),
    // allow_same[24], zero padding[31:25].
    input  wire logic [31:0] s_tdata,
    // s_tuser: op[2:0].
    input  wire logic [2:0]  s_tuser,
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, from bit 0: ok[0], cursor_index[7:1] (signed),
    // word_count[14:8], trigram_len[16:15], context_word1[32:17],
    // context_word2[48:33], context_word3[64:49], zero padding[71:65].
    output logic [71:0]      m_tdata,
    // m_tuser: trigram_sent[0].
    output logic             m_tuser
);

    cwlt_pkg::cmd_t    cmd;
    cwlt_pkg::status_t status;

    logic                                   res_ok;
    logic [cwlt_pkg::IDX_W-1:0]             res_cursor_index;
    logic [cwlt_pkg::IDX_W-1:0]             res_word_count;
    logic [cwlt_pkg::LEN_W-1:0]             res_trigram_len;
    logic [cwlt_pkg::WORD_W-1:0]            res_ctx1, res_ctx2, res_ctx3;

    // The controller sequences shift, insert write, context reads and the
    // hand-off into the output register.
    cwlt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath decides each operation in the cycle it is accepted and
    // holds the list state, the word memory and the result registers.
    cwlt_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_op             (s_tuser),
        .in_word           (s_tdata[15:0]),
        .in_amount         (s_tdata[23:16]),
        .in_allow_same     (s_tdata[24]),
        .out_ok            (res_ok),
        .out_cursor_index  (res_cursor_index),
        .out_word_count    (res_word_count),
        .out_trigram_sent  (m_tuser),
        .out_trigram_len   (res_trigram_len),
        .out_context_word1 (res_ctx1),
        .out_context_word2 (res_ctx2),
        .out_context_word3 (res_ctx3)
    );

    assign m_tdata = {7'd0, res_ctx3, res_ctx2, res_ctx1, res_trigram_len,
                      res_word_count, res_cursor_index, res_ok};

endmodule

`default_nettype wire

FILE: sv/cwlt_checker.sv
`default_nettype none

module cwlt_props (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser
);

    // One operation at a time: an accepted word closes the input for a while.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after an accepted word");

    // A stalled result stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Context words only come with a carried-out operation.
    a_sent_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[0])
        else $error("context sent for a refused operation");

    // Without context the length and all context words are zero.
    a_no_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[64:15] == '0))
        else $error("stray context on a result without context");

    // The list never reports more entries than it can hold.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:8] <= 7'(cwlt_pkg::CAPACITY)))
        else $error("word count beyond capacity");

endmodule

bind cursor_word_list_with_trigram cwlt_props u_cwlt_props (.*);

`default_nettype wire

FILE: bench/cwlt_checker.sv
`default_nettype none

// Watches both channels of the cursor word list. Every accepted operation
// word is run through a private copy of the list and the expected result is
// queued; every accepted result word is compared with the oldest entry.
module cwlt_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,
    input  wire logic        m_tuser,
    output int               errors,
    output int               outstanding,
    output int               results_seen,
    output int               refused_seen,
    output int               context_seen,
    output int               peak_fill
);

    typedef struct packed {
        logic                                               ok;
        logic [cwlt_pkg::IDX_W-1:0]                         cursor_index;
        logic [cwlt_pkg::IDX_W-1:0]                         word_count;
        logic                                               trigram_sent;
        logic [cwlt_pkg::LEN_W-1:0]                         trigram_len;
        logic [cwlt_pkg::CTX_LEN-1:0][cwlt_pkg::WORD_W-1:0] ctx;
    } edit_result_t;

    logic [cwlt_pkg::WORD_W-1:0] list_words [cwlt_pkg::CAPACITY];
    int                          cur_pos;
    int                          n_words;
    edit_result_t                expected_results [$];
    edit_result_t                want_r;
    edit_result_t                got_r;

    // Applies one operation to the private list and returns what the block
    // must answer.
    function automatic edit_result_t apply_edit(
        input logic [cwlt_pkg::OP_W-1:0]          op,
        input logic [cwlt_pkg::WORD_W-1:0]        w,
        input logic signed [cwlt_pkg::AMT_W-1:0]  amt,
        input logic                               same
    );
        edit_result_t r;
        int           np;
        int           k;
        r = '0;
        case (op)
            cwlt_pkg::OP_INSERT: begin
                if (n_words < cwlt_pkg::CAPACITY) begin
                    for (k = n_words; k > cur_pos; k--) list_words[k] = list_words[k - 1];
                    list_words[cur_pos] = w;
                    n_words++;
                    cur_pos++;
                    r.ok = 1'b1;
                end
            end
            cwlt_pkg::OP_MOVE: begin
                np = cur_pos + int'(amt);
                if (n_words != 0 && np >= 0 && np <= n_words && (amt != 0 || same)) begin
                    cur_pos        = np;
                    r.ok           = 1'b1;
                    r.trigram_sent = 1'b1;
                end
            end
            cwlt_pkg::OP_DEL_NEXT: begin
                if (cur_pos < n_words) begin
                    for (k = cur_pos; k + 1 < n_words; k++) list_words[k] = list_words[k + 1];
                    n_words--;
                    r.ok = 1'b1;
                end
            end
            cwlt_pkg::OP_DEL_PREV: begin
                if (cur_pos != 0) begin
                    for (k = cur_pos - 1; k + 1 < n_words; k++) list_words[k] = list_words[k + 1];
                    n_words--;
                    cur_pos--;
                    r.ok           = 1'b1;
                    r.trigram_sent = 1'b1;
                end
            end
            cwlt_pkg::OP_CLEAR: begin
                n_words = 0;
                cur_pos = 0;
                r.ok    = 1'b1;
            end
            default: begin
            end
        endcase
        r.cursor_index = cwlt_pkg::IDX_W'(cur_pos - 1);
        r.word_count   = cwlt_pkg::IDX_W'(n_words);
        if (r.trigram_sent) begin
            for (k = 0; k < cwlt_pkg::CTX_LEN && k < cur_pos; k++) begin
                r.ctx[k] = list_words[cur_pos - 1 - k];
            end
            r.trigram_len = cwlt_pkg::LEN_W'(k);
        end
        return r;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_pos      = 0;
            n_words      = 0;
            errors       = 0;
            outstanding  = 0;
            results_seen = 0;
            refused_seen = 0;
            context_seen = 0;
            peak_fill    = 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_edit(s_tuser, s_tdata[15:0], s_tdata[23:16],
                                                      s_tdata[24]));
                if (n_words > peak_fill) peak_fill = n_words;
            end
            if (m_tvalid && m_tready) begin
                got_r.ok           = m_tdata[0];
                got_r.cursor_index = m_tdata[7:1];
                got_r.word_count   = m_tdata[14:8];
                got_r.trigram_len  = m_tdata[16:15];
                got_r.ctx[0]       = m_tdata[32:17];
                got_r.ctx[1]       = m_tdata[48:33];
                got_r.ctx[2]       = m_tdata[64:49];
                got_r.trigram_sent = m_tuser;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word 0x%0h with nothing pending", m_tdata));
                end else begin
                    want_r = expected_results.pop_front();
                    if (want_r.ok == 1'b0) refused_seen++;
                    if (want_r.trigram_sent) context_seen++;
                    if (got_r.ok != want_r.ok)
                        report_mismatch($sformatf("ok %0d, expected %0d", got_r.ok, want_r.ok));
                    if (got_r.cursor_index != want_r.cursor_index)
                        report_mismatch($sformatf("cursor_index %0d, expected %0d",
                                                  $signed(got_r.cursor_index),
                                                  $signed(want_r.cursor_index)));
                    if (got_r.word_count != want_r.word_count)
                        report_mismatch($sformatf("word_count %0d, expected %0d",
                                                  got_r.word_count, want_r.word_count));
                    if (got_r.trigram_sent != want_r.trigram_sent)
                        report_mismatch($sformatf("trigram_sent %0d, expected %0d",
                                                  got_r.trigram_sent, want_r.trigram_sent));
                    if (got_r.trigram_len != want_r.trigram_len)
                        report_mismatch($sformatf("trigram_len %0d, expected %0d",
                                                  got_r.trigram_len, want_r.trigram_len));
                    if (got_r.ctx[0] != want_r.ctx[0])
                        report_mismatch($sformatf("context_word1 0x%0h, expected 0x%0h",
                                                  got_r.ctx[0], want_r.ctx[0]));
                    if (got_r.ctx[1] != want_r.ctx[1])
                        report_mismatch($sformatf("context_word2 0x%0h, expected 0x%0h",
                                                  got_r.ctx[1], want_r.ctx[1]));
                    if (got_r.ctx[2] != want_r.ctx[2])
                        report_mismatch($sformatf("context_word3 0x%0h, expected 0x%0h",
                                                  got_r.ctx[2], want_r.ctx[2]));
                end
                if (m_tdata[71:65] != '0)
                    report_mismatch($sformatf("padding bits 0x%0h not zero", m_tdata[71:65]));
                results_seen++;
            end
            outstanding = expected_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_cursor_word_list_with_trigram.sv
`default_nettype none

// Stimulus and verdict for the cursor word list. A checker beside the block
// predicts and compares every result word; this module only drives the
// operation channel, paces the result channel and reports the outcome.
module tb_cursor_word_list_with_trigram;

    // Operation words in the random part; the directed part adds a few dozen.
    localparam int RANDOM_ITEMS  = 1310;
    // The last stretch of the random part runs without any idling.
    localparam int CALM_ITEMS    = 150;
    // Length of the one long receiver hold-off.
    localparam int HOLD_CYCLES   = 300;
    // Idle time at the end, long enough to cover one more operation.
    localparam int SETTLE_CYCLES = 100;
    // The slowest correct run is near 1350 words, each with the longest operation
    // and both idle bursts, plus the long hold; this is several times that.
    localparam int CYCLE_LIMIT   = 800000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;

    int errors;
    int outstanding;
    int results_seen;
    int refused_seen;
    int context_seen;
    int peak_fill;

    int   cycles       = 0;
    int   ops_counted  = 0;
    // Idling switches, changed per run so that quiet stretches also occur.
    logic tx_noisy     = 1'b1;
    logic rx_noisy     = 1'b1;
    // Handshake between the main process and the receiver for the long hold.
    logic rx_hold_req  = 1'b0;
    logic rx_hold_done = 1'b0;

    cursor_word_list_with_trigram dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cwlt_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .refused_seen (refused_seen),
        .context_seen (context_seen),
        .peak_fill    (peak_fill)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // A hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d results still pending",
                     CYCLE_LIMIT, outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one operation word, waits until the block takes it, and then,
    // when idling is on, sometimes leaves the channel empty for a burst.
    // Inputs change only at the falling edge, so the block and the checker
    // both see stable values at the rising edge.
    task automatic offer(input logic [cwlt_pkg::OP_W-1:0] op,
                         input logic [cwlt_pkg::WORD_W-1:0] w,
                         input int amt, input logic same);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, same, 8'(amt), w};
        do @(posedge aclk); while (!s_tready);
        ops_counted++;
        if (tx_noisy && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 17)) @(negedge aclk);
        end
    endtask

    // Stops sending and waits until every expected result word has arrived.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Receiver pacing. It stalls in random bursts while rx_noisy is set, and
    // once, on request, holds off long enough for the block to fill its
    // output register and its working slot and push back on the input side.
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_req && !rx_hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                rx_hold_done <= 1'b1;
            end else if (rx_noisy && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int                        kind;
        int                        run_len;
        int                        j;
        int                        pick;
        int                        amt;
        int                        calm_from;
        int                        stop_at;
        bit                        first_run;
        logic [cwlt_pkg::OP_W-1:0] op;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A move and both deletes on the empty list are refused first.
        offer(cwlt_pkg::OP_MOVE, 16'hFFFF, 1, 1'b1);
        offer(cwlt_pkg::OP_DEL_NEXT, 16'h0000, 0, 1'b0);
        offer(cwlt_pkg::OP_DEL_PREV, 16'h0000, 0, 1'b0);
        // Extremes of the word field, and a fourth word so that the
        // context is clipped to three.
        offer(cwlt_pkg::OP_INSERT, 16'h0000, 0, 1'b0);
        offer(cwlt_pkg::OP_INSERT, 16'hFFFF, 0, 1'b0);
        offer(cwlt_pkg::OP_INSERT, 16'hA5A5, -1, 1'b1);
        offer(cwlt_pkg::OP_INSERT, 16'h5A5A, 64, 1'b0);
        // A move of zero is refused without allow_same and accepted with it.
        offer(cwlt_pkg::OP_MOVE, 16'h1234, 0, 1'b0);
        offer(cwlt_pkg::OP_MOVE, 16'h1234, 0, 1'b1);
        // With the cursor at the end there is nothing to delete forward.
        offer(cwlt_pkg::OP_DEL_NEXT, 16'h0000, 0, 1'b0);
        // Displacements of 64 and -64 both run off the list.
        offer(cwlt_pkg::OP_MOVE, 16'h0000, 64, 1'b0);
        offer(cwlt_pkg::OP_MOVE, 16'h0000, -64, 1'b1);
        // Back to the start: the context is empty there.
        offer(cwlt_pkg::OP_MOVE, 16'h0000, -4, 1'b0);
        offer(cwlt_pkg::OP_DEL_PREV, 16'h0000, 0, 1'b0);
        offer(cwlt_pkg::OP_MOVE, 16'h0000, 1, 1'b0);
        offer(cwlt_pkg::OP_MOVE, 16'h0000, 1, 1'b0);
        offer(cwlt_pkg::OP_DEL_NEXT, 16'hFFFF, 0, 1'b1);
        offer(cwlt_pkg::OP_DEL_PREV, 16'h0000, 0, 1'b0);
        offer(cwlt_pkg::OP_INSERT, 16'h8001, 0, 1'b0);
        // Undefined op codes are answered but change nothing.
        offer(3'd5, 16'($urandom), int'($urandom_range(0, 255)), 1'b1);
        offer(3'd6, 16'($urandom), int'($urandom_range(0, 255)), 1'b0);
        offer(3'd7, 16'($urandom), int'($urandom_range(0, 255)), 1'b1);
        offer(cwlt_pkg::OP_MOVE, 16'h0000, -1, 1'b0);
        offer(cwlt_pkg::OP_CLEAR, 16'hFFFF, -1, 1'b1);
        offer(cwlt_pkg::OP_MOVE, 16'h0000, 1, 1'b1);
        drain_results();

        // Back pressure: the receiver holds off while words keep coming
        // without gaps, so the block has to stall its input.
        tx_noisy = 1'b0;
        rx_hold_req <= 1'b1;
        for (j = 0; j < 12; j++) begin
            offer(cwlt_pkg::OP_INSERT, 16'($urandom), 0, 1'b0);
        end
        drain_results();

        // Random part, built from runs. Fill runs grow the list, drain runs
        // shrink it, mixed runs edit around the cursor, and noise runs send
        // any op code, undefined ones included. The first run clears and fills
        // past capacity so the full store is hit early.
        calm_from = ops_counted + RANDOM_ITEMS - CALM_ITEMS;
        stop_at   = ops_counted + RANDOM_ITEMS;
        first_run = 1'b1;
        while (ops_counted < stop_at) begin
            kind      = first_run ? 8 : int'($urandom_range(0, 9));
            first_run = 1'b0;
            if (ops_counted >= calm_from) begin
                tx_noisy = 1'b0;
                rx_noisy <= 1'b0;
            end else begin
                tx_noisy = ($urandom_range(0, 3) != 0);
                rx_noisy <= ($urandom_range(0, 3) != 0);
            end
            case (kind)
                8:       run_len = $urandom_range(66, 72);
                9:       run_len = $urandom_range(5, 15);
                default: run_len = $urandom_range(20, 70);
            endcase
            for (j = 0; j < run_len && ops_counted < stop_at; j++) begin
                pick = $urandom_range(0, 99);
                case (kind)
                    0, 1, 2: begin
                        op = (pick < 85) ? cwlt_pkg::OP_INSERT : cwlt_pkg::OP_MOVE;
                    end
                    6, 7: begin
                        op = (pick < 45) ? cwlt_pkg::OP_DEL_PREV :
                             (pick < 90) ? cwlt_pkg::OP_DEL_NEXT : cwlt_pkg::OP_MOVE;
                    end
                    8: begin
                        op = (j == 0) ? cwlt_pkg::OP_CLEAR : cwlt_pkg::OP_INSERT;
                    end
                    9: begin
                        op = 3'($urandom_range(0, 7));
                    end
                    default: begin
                        if (pick < 32) op = cwlt_pkg::OP_INSERT;
                        else if (pick < 60) op = cwlt_pkg::OP_MOVE;
                        else if (pick < 74) op = cwlt_pkg::OP_DEL_NEXT;
                        else if (pick < 90) op = cwlt_pkg::OP_DEL_PREV;
                        else if (pick < 92) op = cwlt_pkg::OP_CLEAR;
                        else op = 3'($urandom_range(5, 7));
                    end
                endcase
                // Mostly short hops that stay on the list, sometimes hops of up to 64
                // either way.
                if ($urandom_range(0, 3) == 0) amt = int'($urandom_range(0, 128)) - 64;
                else amt = int'($urandom_range(0, 8)) - 4;
                offer(op, 16'($urandom), amt, 1'($urandom_range(0, 1)));
            end
            // Now and then the sender waits for the block to go idle, but
            // not in the quiet stretch at the end.
            if (ops_counted < calm_from && $urandom_range(0, 7) == 0) drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Checked %0d result words: %0d refused, %0d carrying context words.",
                 results_seen, refused_seen, context_seen);
        $display("Sent %0d operation words; the list peaked at %0d of %0d entries.",
                 ops_counted, peak_fill, cwlt_pkg::CAPACITY);
        if (errors == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d result words never arrived", errors, outstanding);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
sv/cwlt_pkg.sv
sv/cwlt_ram.sv
sv/cwlt_ctrl.sv
sv/cwlt_datapath.sv
sv/cursor_word_list_with_trigram.sv
sv/cwlt_checker.sv
bench/cwlt_checker.sv
bench/tb_cursor_word_list_with_trigram.sv
